FILE: src/assert_macros.svh
// Assertion macros used by the max flow RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mfap_pkg.sv
// Shared types and constants of the max flow block.
`timescale 1ns / 1ps

package mfap_pkg;

   localparam int NODE_BITS = 4;
   localparam int KIND_BITS = 2;
   localparam int PORT_CAP_BITS = 16;
   localparam int FLOW_BITS = 20;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [NODE_BITS-1:0] node_type;
   typedef logic [FLOW_BITS-1:0] flow_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam kind_type KIND_EDGE  = 2'd0;
   localparam kind_type KIND_RUN   = 2'd1;
   localparam kind_type KIND_CLEAR = 2'd2;

   localparam csr_index_type CSR_SOURCE = 1'd0;
   localparam csr_index_type CSR_TARGET = 1'd1;

   localparam node_type SOURCE_RESET = 4'd0;
   localparam node_type TARGET_RESET = 4'd15;

endpackage

FILE: src/max_flow_augmenting_path.sv
// Max flow block: capacity matrix, depth-first augmenting path search, flow sum.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Max flow over a directed graph of NODES nodes (Ford-Fulkerson, DFS paths).
// Commands enter on start while busy is low: set edge, clear matrix and
// run. A run gives exactly one result on rsp_valid for one cycle; the
// receiver cannot stall, so take it when shown. A run first copies the
// capacities into the residual matrix, then per augmenting path makes one
// search (every popped node scans its matrix row through the single residual
// read port, one entry a cycle) and then the bottleneck and update walks
// along the path; a final failing search ends it. Runs with a bad or equal
// source/target answer 0 in the cycle after the command is taken. After
// reset the capacity memory is swept to zero with busy high; csr writes are
// always taken (csr_ready stays high); the user must write them only while
// idle, as the block itself does not enforce it.
module max_flow_augmenting_path #(
   parameter int NODES = 16,
   parameter int CAP_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mfap_pkg::kind_type             req_kind,
   input  mfap_pkg::node_type             req_from_node,
   input  mfap_pkg::node_type             req_to_node,
   input  logic [mfap_pkg::PORT_CAP_BITS-1:0] req_capacity,
   output logic                           rsp_valid,
   output mfap_pkg::flow_type             rsp_max_flow,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  mfap_pkg::csr_index_type        csr_index,
   input  mfap_pkg::node_type             csr_data
);

   localparam int NB  = $clog2(NODES);
   localparam int AW  = $clog2(NODES * NODES);
   localparam int SW  = $clog2(NODES + 1);
   localparam int RW  = CAP_BITS + 1;
   localparam int CELLS = NODES * NODES;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_COPY  = 4'd2;
   localparam logic [3:0] S_INIT  = 4'd3;
   localparam logic [3:0] S_POP   = 4'd4;
   localparam logic [3:0] S_POPW  = 4'd5;
   localparam logic [3:0] S_SCAN  = 4'd6;
   localparam logic [3:0] S_NK_R  = 4'd7;
   localparam logic [3:0] S_NK_V  = 4'd8;
   localparam logic [3:0] S_NK_D  = 4'd9;
   localparam logic [3:0] S_PU_R  = 4'd10;
   localparam logic [3:0] S_PU_V  = 4'd11;
   localparam logic [3:0] S_PU_F  = 4'd12;
   localparam logic [3:0] S_PU_B  = 4'd13;

   function automatic logic [AW-1:0] mat_addr(input logic [NB-1:0] row,
                                              input logic [NB-1:0] col);
      return AW'(AW'(row) * AW'(NODES) + AW'(col));
   endfunction

   // memories
   logic [CAP_BITS-1:0] cap_mem [CELLS];
   logic [RW-1:0]       res_mem [CELLS];
   logic [NB-1:0]       reach_mem [NODES];
   logic [NB-1:0]       stack_mem [NODES+1];

   logic                cap_we;
   logic [AW-1:0]       cap_waddr, cap_raddr;
   logic [CAP_BITS-1:0] cap_wdata, cap_q;
   logic                res_we;
   logic [AW-1:0]       res_waddr, res_raddr;
   logic [RW-1:0]       res_wdata, res_q;
   logic                reach_we;
   logic [NB-1:0]       reach_waddr, reach_wdata, reach_raddr, reach_q;
   logic                stack_we;
   logic [SW-1:0]       stack_waddr, stack_raddr;
   logic [NB-1:0]       stack_wdata, stack_q;

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_waddr] <= cap_wdata;
      end
      cap_q <= cap_mem[cap_raddr];
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      res_q <= res_mem[res_raddr];
   end

   always_ff @(posedge clock) begin
      if (reach_we) begin
         reach_mem[reach_waddr] <= reach_wdata;
      end
      reach_q <= reach_mem[reach_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_q <= stack_mem[stack_raddr];
   end

   // control and datapath registers
   logic [3:0]          state_ff, state_in;
   logic [AW:0]         cnt_ff, cnt_in;
   logic [NODES-1:0]    vld_ff, vld_in;
   logic [SW-1:0]       depth_ff, depth_in;
   logic [NB-1:0]       src_ff, src_in, dst_ff, dst_in;
   logic [NB-1:0]       cur_ff, cur_in, w_ff, w_in, v_ff, v_in, wd_ff, wd_in;
   logic [SW-1:0]       wcnt_ff, wcnt_in;
   logic                scan_vld_ff, scan_vld_in;
   logic [RW-1:0]       neck_ff, neck_in;
   mfap_pkg::flow_type  total_ff, total_in;
   mfap_pkg::flow_type  flow_ff, flow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mfap_pkg::node_type  csr_source_ff, csr_source_in, csr_target_ff, csr_target_in;

   logic                accept;
   logic                ends_ok;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_flow = flow_ff;
   assign ends_ok = (32'(csr_source_ff) < NODES) && (32'(csr_target_ff) < NODES) &&
                    (csr_source_ff != csr_target_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      vld_in        = vld_ff;
      depth_in      = depth_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      cur_in        = cur_ff;
      w_in          = w_ff;
      v_in          = v_ff;
      wd_in         = wd_ff;
      wcnt_in       = wcnt_ff;
      scan_vld_in   = 1'b0;
      neck_in       = neck_ff;
      total_in      = total_ff;
      flow_in       = flow_ff;
      rsp_valid_in  = 1'b0;
      csr_source_in = csr_source_ff;
      csr_target_in = csr_target_ff;

      cap_we      = 1'b0;
      cap_waddr   = cnt_ff[AW-1:0];
      cap_wdata   = '0;
      cap_raddr   = cnt_ff[AW-1:0];
      res_we      = 1'b0;
      res_waddr   = mat_addr(v_ff, w_ff);
      res_wdata   = res_q - neck_ff;
      res_raddr   = mat_addr(v_ff, w_ff);
      reach_we    = 1'b0;
      reach_waddr = wd_ff;
      reach_wdata = cur_ff;
      reach_raddr = w_ff;
      stack_we    = 1'b0;
      stack_waddr = depth_ff;
      stack_wdata = wd_ff;
      stack_raddr = depth_ff - SW'(1);

      if (csr_valid) begin
         case (csr_index)
            mfap_pkg::CSR_SOURCE: csr_source_in = csr_data;
            mfap_pkg::CSR_TARGET: csr_target_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            cap_we = 1'b1;
            cnt_in = cnt_ff + (AW+1)'(1);
            if (cnt_ff == (AW+1)'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  mfap_pkg::KIND_EDGE: begin
                     if ((32'(req_from_node) < NODES) && (32'(req_to_node) < NODES)) begin
                        cap_we    = 1'b1;
                        cap_waddr = mat_addr(NB'(req_from_node), NB'(req_to_node));
                        cap_wdata = CAP_BITS'(req_capacity);
                     end
                  end
                  mfap_pkg::KIND_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  mfap_pkg::KIND_RUN: begin
                     if (ends_ok) begin
                        src_in   = NB'(csr_source_ff);
                        dst_in   = NB'(csr_target_ff);
                        total_in = '0;
                        cnt_in   = '0;
                        state_in = S_COPY;
                     end else begin
                        flow_in      = '0;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_COPY: begin
            // read at cnt, write the previous entry from the registered data
            cnt_in    = cnt_ff + (AW+1)'(1);
            res_waddr = AW'(cnt_ff - (AW+1)'(1));
            res_wdata = RW'(cap_q);
            res_we    = (cnt_ff != '0);
            if (cnt_ff == (AW+1)'(CELLS)) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            vld_in         = '0;
            vld_in[src_ff] = 1'b1;
            reach_we       = 1'b1;
            reach_waddr    = src_ff;
            reach_wdata    = src_ff;
            stack_we       = 1'b1;
            stack_waddr    = '0;
            stack_wdata    = src_ff;
            depth_in       = SW'(1);
            state_in       = S_POP;
         end
         S_POP: begin
            if (vld_ff[dst_ff]) begin
               w_in     = dst_ff;
               neck_in  = '0;
               state_in = S_NK_R;
            end else if (depth_ff == '0) begin
               flow_in      = total_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               depth_in = depth_ff - SW'(1);
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            cur_in   = stack_q;
            wcnt_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // issue row read for wcnt, judge the entry read last cycle
            res_raddr = mat_addr(cur_ff, NB'(wcnt_ff));
            if (wcnt_ff != SW'(NODES)) begin
               scan_vld_in = 1'b1;
               wd_in       = NB'(wcnt_ff);
               wcnt_in     = wcnt_ff + SW'(1);
            end else begin
               state_in = S_POP;
            end
            if (scan_vld_ff && (res_q != '0) && !vld_ff[wd_ff]) begin
               vld_in[wd_ff] = 1'b1;
               reach_we      = 1'b1;
               stack_we      = 1'b1;
               depth_in      = depth_ff + SW'(1);
            end
         end
         S_NK_R: begin
            state_in = S_NK_V;
         end
         S_NK_V: begin
            v_in      = reach_q;
            res_raddr = mat_addr(reach_q, w_ff);
            state_in  = S_NK_D;
         end
         S_NK_D: begin
            if ((neck_ff == '0) || (res_q < neck_ff)) begin
               neck_in = res_q;
            end
            w_in = v_ff;
            if (v_ff == src_ff) begin
               w_in     = dst_ff;
               state_in = S_PU_R;
            end else begin
               state_in = S_NK_R;
            end
         end
         S_PU_R: begin
            state_in = S_PU_V;
         end
         S_PU_V: begin
            v_in      = reach_q;
            res_raddr = mat_addr(reach_q, w_ff);
            state_in  = S_PU_F;
         end
         S_PU_F: begin
            res_we    = 1'b1;
            res_waddr = mat_addr(v_ff, w_ff);
            res_wdata = res_q - neck_ff;
            res_raddr = mat_addr(w_ff, v_ff);
            state_in  = S_PU_B;
         end
         S_PU_B: begin
            res_we    = 1'b1;
            res_waddr = mat_addr(w_ff, v_ff);
            res_wdata = res_q + neck_ff;
            w_in      = v_ff;
            if (v_ff == src_ff) begin
               total_in = total_ff + mfap_pkg::FLOW_BITS'(neck_ff);
               state_in = S_INIT;
            end else begin
               state_in = S_PU_R;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         depth_ff      <= '0;
         scan_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
         flow_ff       <= '0;
         vld_ff        <= '0;
         csr_source_ff <= mfap_pkg::SOURCE_RESET;
         csr_target_ff <= mfap_pkg::TARGET_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         depth_ff      <= depth_in;
         scan_vld_ff   <= scan_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         total_ff      <= total_in;
         flow_ff       <= flow_in;
         vld_ff        <= vld_in;
         csr_source_ff <= csr_source_in;
         csr_target_ff <= csr_target_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      cur_ff  <= cur_in;
      w_ff    <= w_in;
      v_ff    <= v_in;
      wd_ff   <= wd_in;
      wcnt_ff <= wcnt_in;
      neck_ff <= neck_in;
   end

   // a result only follows a run in progress or a run command just taken
   `ASSERT_CLK(a_rsp_from_run,
      !rsp_valid || $past(busy || (start && (req_kind == mfap_pkg::KIND_RUN))),
      "result without a run")
   // each node is pushed once, so the stack never overflows
   `ASSERT_CLK(a_depth_bound, depth_ff <= SW'(NODES), "search stack overflow")
   // the node whose row is scanned was reached
   `ASSERT_CLK(a_cur_reached, (state_ff != S_SCAN) || vld_ff[cur_ff],
      "scanning an unreached node")
   // a finished path always carries positive flow
   `ASSERT_NEXT(a_neck_positive, (state_ff == S_NK_D) && (v_ff == src_ff),
      neck_ff != '0, "zero bottleneck on found path")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the max flow block: command driver, result monitor, flow predictor.
`timescale 1ns / 1ps

module tb;

   // Kind code the block must ignore (no result, no state change).
   localparam mfap_pkg::kind_type KIND_UNUSED = 2'd3;
   localparam int N = 16;

   typedef struct {
      mfap_pkg::kind_type   kind;
      mfap_pkg::node_type   from_node;
      mfap_pkg::node_type   to_node;
      logic [15:0] capacity;
   } command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   mfap_pkg::kind_type    req_kind = mfap_pkg::KIND_EDGE;
   mfap_pkg::node_type    req_from_node = '0;
   mfap_pkg::node_type    req_to_node = '0;
   logic [15:0] req_capacity = '0;
   logic        rsp_valid;
   mfap_pkg::flow_type    rsp_max_flow;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   mfap_pkg::csr_index_type csr_index = mfap_pkg::CSR_SOURCE;
   mfap_pkg::node_type    csr_data = '0;

   max_flow_augmenting_path dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_capacity(req_capacity), .rsp_valid(rsp_valid), .rsp_max_flow(rsp_max_flow),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Predictor state: own copy of the capacity matrix and endpoint registers.
   longint   graph_cap [N*N];
   longint   residual [N*N];
   int       parent [N];
   int       dfs_stack [N+1];
   mfap_pkg::node_type flow_src = mfap_pkg::SOURCE_RESET;
   mfap_pkg::node_type flow_dst = mfap_pkg::TARGET_RESET;

   command_type pending_cmds[$];
   mfap_pkg::flow_type flow_expected[$];
   int       mismatches = 0;
   logic     took = 1'b0;   // transfer happened at the last rising edge
   int       gap_left = 0;

   // One depth-first search; fills parent[], returns the bottleneck or 0.
   function automatic longint augment_once(int s, int t);
      int depth, cur, w;
      longint neck;
      for (int v = 0; v < N; v++) parent[v] = N;
      parent[s] = s;
      depth = 0;
      dfs_stack[depth] = s;
      depth = depth + 1;
      while (depth > 0 && parent[t] == N) begin
         depth = depth - 1;
         cur = dfs_stack[depth];
         for (w = 0; w < N; w++)
            if (residual[cur*N+w] != 0 && parent[w] == N && depth < N+1) begin
               parent[w] = cur;
               dfs_stack[depth] = w;
               depth = depth + 1;
            end
      end
      if (parent[t] == N) return 0;
      neck = 0;
      w = t;
      while (w != s) begin
         if (neck == 0 || residual[parent[w]*N+w] < neck) neck = residual[parent[w]*N+w];
         w = parent[w];
      end
      return neck;
   endfunction

   function automatic mfap_pkg::flow_type predict_flow();
      longint total, amt;
      int w, v;
      total = 0;
      if (flow_src == flow_dst) return '0;
      for (int i = 0; i < N*N; i++) residual[i] = graph_cap[i];
      forever begin
         amt = augment_once(flow_src, flow_dst);
         if (amt == 0) break;
         w = flow_dst;
         while (w != flow_src) begin
            v = parent[w];
            residual[v*N+w] -= amt;
            residual[w*N+v] += amt;
            w = v;
         end
         total += amt;
      end
      return mfap_pkg::flow_type'(total);
   endfunction

   task automatic report_mismatch(string what, mfap_pkg::flow_type got,
                                  mfap_pkg::flow_type want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Monitor: model update on each command transfer, result check on each strobe.
   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
         for (int i = 0; i < N*N; i++) graph_cap[i] = 0;
      end else begin
         if (rsp_valid) begin
            if (flow_expected.size() == 0) report_mismatch("unexpected result", rsp_max_flow, '0);
            else begin
               mfap_pkg::flow_type want;
               want = flow_expected.pop_front();
               if (rsp_max_flow !== want) report_mismatch("max_flow", rsp_max_flow, want);
            end
         end
         took <= start && !busy;
         if (start && !busy) begin
            case (req_kind)
               mfap_pkg::KIND_EDGE: graph_cap[req_from_node*N+req_to_node] = req_capacity;
               mfap_pkg::KIND_CLEAR: for (int i = 0; i < N*N; i++) graph_cap[i] = 0;
               mfap_pkg::KIND_RUN: flow_expected.push_back(predict_flow());
               default: ;
            endcase
         end
      end
   end

   // Driver: holds start until transfer, then leaves a random gap before the next command.
   always @(negedge clock) begin
      if (!reset && (!start || took)) begin
         int g;
         g = gap_left;
         if (start && took) g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
         if (g > 0) begin
            gap_left <= g - 1;
            start <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            command_type c;
            c = pending_cmds.pop_front();
            gap_left <= 0;
            req_kind <= c.kind;
            req_from_node <= c.from_node;
            req_to_node <= c.to_node;
            req_capacity <= c.capacity;
            start <= 1'b1;
         end else begin
            gap_left <= 0;
            start <= 1'b0;
         end
      end
   end

   task automatic queue_cmd(mfap_pkg::kind_type k, int f, int t, int cap);
      command_type c;
      c.kind = k;
      c.from_node = mfap_pkg::node_type'(f);
      c.to_node = mfap_pkg::node_type'(t);
      c.capacity = 16'(cap);
      pending_cmds.push_back(c);
   endtask

   // Drain the command queue and let a trailing clear finish before touching registers.
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || start || flow_expected.size() != 0) @(posedge clock);
      repeat (N*N + 20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(mfap_pkg::csr_index_type idx, int value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= mfap_pkg::node_type'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == mfap_pkg::CSR_SOURCE) flow_src = mfap_pkg::node_type'(value);
      else flow_dst = mfap_pkg::node_type'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Pick a node, mostly an endpoint or one of a small cluster at the hub, so paths exist.
   function automatic int pick_node(int a, int b, int c);
      case ($urandom_range(0, 5))
         0: return a;
         1: return b;
         2, 3: return c + $urandom_range(0, 2);
         default: return $urandom_range(0, N-1);
      endcase
   endfunction

   function automatic int pick_cap();
      case ($urandom_range(0, 9))
         0: return 0;
         1, 2: return $urandom & 16'hFFFF;
         default: return $urandom_range(1, 15);
      endcase
   endfunction

   // Random graphs: mostly clear / edges / run sequences, with some noise.
   task automatic queue_random(int count);
      int sent, nedge, hub;
      sent = 0;
      while (sent < count) begin
         hub = $urandom_range(0, N-3);
         if ($urandom_range(0, 3) != 0) begin
            queue_cmd(mfap_pkg::KIND_CLEAR, $urandom_range(0, N-1), $urandom_range(0, N-1),
                      $urandom);
            sent++;
         end
         nedge = $urandom_range(3, 12);
         for (int i = 0; i < nedge; i++) begin
            if ($urandom_range(0, 9) == 0)
               queue_cmd(mfap_pkg::kind_type'($urandom_range(0, 3)), $urandom_range(0, N-1),
                         $urandom_range(0, N-1), $urandom);
            else
               queue_cmd(mfap_pkg::KIND_EDGE, pick_node(flow_src, flow_dst, hub),
                         pick_node(flow_dst, flow_src, hub), pick_cap());
            sent++;
         end
         queue_cmd(mfap_pkg::KIND_RUN, $urandom_range(0, N-1), $urandom_range(0, N-1),
                   $urandom);
         sent++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full-scale single edge, chained bottleneck, self loop,
      // ignored kind, zero capacity removes an edge, clear, reverse edge.
      queue_cmd(mfap_pkg::KIND_RUN, 0, 0, 0);
      queue_cmd(mfap_pkg::KIND_EDGE, 0, 15, 16'hFFFF);
      queue_cmd(mfap_pkg::KIND_RUN, 15, 15, 16'hFFFF);
      queue_cmd(mfap_pkg::KIND_EDGE, 0, 1, 16'hFFFF);
      queue_cmd(mfap_pkg::KIND_EDGE, 1, 15, 16'hFFFF);
      queue_cmd(mfap_pkg::KIND_EDGE, 1, 1, 16'hFFFF);
      queue_cmd(mfap_pkg::KIND_EDGE, 15, 0, 7);
      queue_cmd(mfap_pkg::KIND_RUN, 0, 0, 0);
      queue_cmd(KIND_UNUSED, 15, 15, 16'hFFFF);
      queue_cmd(mfap_pkg::KIND_EDGE, 0, 15, 0);
      queue_cmd(mfap_pkg::KIND_EDGE, 0, 2, 3);
      queue_cmd(mfap_pkg::KIND_EDGE, 2, 1, 5);
      queue_cmd(mfap_pkg::KIND_EDGE, 1, 15, 4);
      queue_cmd(mfap_pkg::KIND_RUN, 0, 0, 0);
      queue_cmd(mfap_pkg::KIND_CLEAR, 10, 5, 16'h5A5A);
      queue_cmd(mfap_pkg::KIND_RUN, 0, 0, 0);
      queue_cmd(mfap_pkg::KIND_EDGE, 0, 15, 1);
      queue_cmd(mfap_pkg::KIND_RUN, 0, 0, 0);
      queue_random(20);
      wait_idle();

      // Endpoints swapped to the opposite extremes.
      write_csr(mfap_pkg::CSR_SOURCE, 15);
      write_csr(mfap_pkg::CSR_TARGET, 0);
      queue_cmd(mfap_pkg::KIND_EDGE, 15, 0, 16'hFFFF);
      queue_cmd(mfap_pkg::KIND_RUN, 0, 0, 0);
      queue_random(20);
      wait_idle();

      // Source equals target: always zero flow.
      write_csr(mfap_pkg::CSR_TARGET, 15);
      queue_random(10);
      wait_idle();

      for (int p = 0; p < 3; p++) begin
         write_csr(mfap_pkg::CSR_SOURCE, $urandom_range(0, N-1));
         write_csr(mfap_pkg::CSR_TARGET, $urandom_range(0, N-1));
         queue_random(20);
         wait_idle();
      end

      while (flow_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && flow_expected.size() == 0) begin
         $display("** max_flow_augmenting_path: PASSED **");
      end else begin
         $display("** max_flow_augmenting_path: FAILED **");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("** max_flow_augmenting_path: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/mfap_pkg.sv
src/max_flow_augmenting_path.sv
verif/tb.sv
